// File: design/btnpd_pkg.sv
// btnpd_pkg: shared types and constants for the button press detector
// no dependencies
package btnpd_pkg;

    localparam int unsigned CfgWidth     = 16;
    localparam int unsigned NowWidth     = 32;
    localparam int unsigned ApbDataWidth = 32;
    localparam int unsigned ApbAddrWidth = 3;
    localparam int unsigned TimeBitsDef  = 32;

    localparam logic [CfgWidth-1:0] DebounceRst  = 16'd50;
    localparam logic [CfgWidth-1:0] LongPressRst = 16'd1000;

    typedef enum logic {
        REG_DEBOUNCE   = 1'b0,
        REG_LONG_PRESS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic short_press;
        logic long_press;
        logic long_held;
    } t_result;

    typedef struct packed {
        logic [CfgWidth-1:0] debounce_ms;
        logic [CfgWidth-1:0] long_press_ms;
    } t_cfg;

endpackage

// File: design/btnpd_cfg.sv
// btnpd_cfg: apb register file for debounce and long-press delays
// depends on btnpd_pkg
module btnpd_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [btnpd_pkg::ApbAddrWidth-1:0]   paddr,
    input  logic [btnpd_pkg::ApbDataWidth-1:0]   pwdata,
    output logic [btnpd_pkg::ApbDataWidth-1:0]   prdata,
    output logic                                 pready,
    output btnpd_pkg::t_cfg                      o_cfg
);
    import btnpd_pkg::*;

    logic [CfgWidth-1:0] r_debounce;
    logic [CfgWidth-1:0] r_long_press;
    logic                wr_en;
    t_reg_idx            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DebounceRst;
            r_long_press <= LongPressRst;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEBOUNCE:   r_debounce   <= pwdata[CfgWidth-1:0];
                REG_LONG_PRESS: r_long_press <= pwdata[CfgWidth-1:0];
                default:        r_debounce   <= r_debounce;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE:   prdata = ApbDataWidth'(r_debounce);
            REG_LONG_PRESS: prdata = ApbDataWidth'(r_long_press);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.debounce_ms   = r_debounce;
    assign o_cfg.long_press_ms = r_long_press;

endmodule

// File: design/btnpd_core.sv
// btnpd_core: debounce and press-timing state with the per-item step logic
// depends on btnpd_pkg
module btnpd_core #(
    parameter int unsigned TIME_BITS = btnpd_pkg::TimeBitsDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [TIME_BITS-1:0]  i_now,
    input  logic                  i_level,
    input  btnpd_pkg::t_cfg       i_cfg,
    output btnpd_pkg::t_result    o_result
);
    import btnpd_pkg::*;

    logic                 r_last_level;
    logic [TIME_BITS-1:0] r_last_change;
    logic [TIME_BITS-1:0] r_press_start;
    logic                 r_long_reached;
    logic                 r_long_taken;

    logic                 n_last_level;
    logic [TIME_BITS-1:0] n_last_change;
    logic [TIME_BITS-1:0] n_press_start;
    logic                 n_long_reached;
    logic                 n_long_taken;

    logic                 changed;
    logic                 bounce;
    logic                 pressed;
    logic [TIME_BITS-1:0] since_change;
    logic [TIME_BITS-1:0] held_time;
    logic                 long_fire;

    always_comb begin
        changed        = i_level != r_last_level;
        pressed        = ~i_level;
        since_change   = i_now - r_last_change;
        bounce         = changed && (since_change <= TIME_BITS'(i_cfg.debounce_ms));
        n_last_level   = i_level;
        n_last_change  = changed ? i_now : r_last_change;
        n_press_start  = changed ? i_now : r_press_start;
        held_time      = i_now - n_press_start;
        n_long_reached = r_long_reached;
        n_long_taken   = r_long_taken;
        o_result.short_press = 1'b0;
        if (!bounce) begin
            if (pressed) begin
                n_long_reached = held_time >= TIME_BITS'(i_cfg.long_press_ms);
            end else begin
                o_result.short_press = ~r_last_level & ~r_long_taken;
                n_long_reached = 1'b0;
                n_long_taken   = 1'b0;
            end
        end
        long_fire = n_long_reached & ~n_long_taken;
        if (long_fire) begin
            n_long_taken = 1'b1;
        end
        o_result.long_press = long_fire;
        o_result.long_held  = n_long_reached;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level   <= 1'b1;
            r_last_change  <= '0;
            r_press_start  <= '0;
            r_long_reached <= 1'b0;
            r_long_taken   <= 1'b0;
        end else if (i_advance) begin
            r_last_level   <= n_last_level;
            r_last_change  <= n_last_change;
            r_press_start  <= n_press_start;
            r_long_reached <= n_long_reached;
            r_long_taken   <= n_long_taken;
        end
    end

endmodule

// File: design/button_short_long_press_detector_top.sv
// button_short_long_press_detector_top: input register, step core, result register
// depends on btnpd_pkg, btnpd_cfg, btnpd_core
//
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_now_ms, i_pin_level
// out       output     o_out_valid / i_out_ready o_short_press, o_long_press, o_long_held
// cfg       input      apb psel/penable/pready   paddr, pwdata, prdata
//
// one item per cycle unless the output stalls; path: input register, result register
// the step core updates its state when the input register moves into the result register
// a stalled result holds; the input register still takes an item while it is empty or advancing
// synchronous active-low reset clears valids, press state and the registers to 50 and 1000
module button_short_long_press_detector_top #(
    parameter int unsigned TIME_BITS = btnpd_pkg::TimeBitsDef
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [btnpd_pkg::NowWidth-1:0]       i_now_ms,
    input  logic                                 i_pin_level,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_short_press,
    output logic                                 o_long_press,
    output logic                                 o_long_held,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [btnpd_pkg::ApbAddrWidth-1:0]   paddr,
    input  logic [btnpd_pkg::ApbDataWidth-1:0]   pwdata,
    output logic [btnpd_pkg::ApbDataWidth-1:0]   prdata,
    output logic                                 pready
);
    import btnpd_pkg::*;

    t_cfg                 cfg;
    t_result              step_res;
    logic                 r_in_valid;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_level;
    logic                 r_out_valid;
    t_result              r_out;
    logic                 advance;

    btnpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    btnpd_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_now     (r_now),
        .i_level   (r_level),
        .i_cfg     (cfg),
        .o_result  (step_res)
    );

    assign advance    = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_now   <= TIME_BITS'(i_now_ms);
            r_level <= i_pin_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_short_press = r_out.short_press;
    assign o_long_press  = r_out.long_press;
    assign o_long_held   = r_out.long_held;

endmodule
